>>> rtl/pwsa_pkg.sv
// ----------------------------------------------------------------------------
// Page window slot allocator package
// Shared sizes, codes and port-group types of the slot allocator.
// ----------------------------------------------------------------------------
package pwsa_pkg;

    localparam int SLOTS      = 256;
    localparam int PAGE_SHIFT = 12;
    localparam int IDX_W      = $clog2(SLOTS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int VPN_W      = 32 - PAGE_SHIFT;

    localparam logic [1:0] ACT_MAP        = 2'd0;
    localparam logic [1:0] ACT_UNMAP_PAGE = 2'd1;
    localparam logic [1:0] ACT_UNMAP_ADDR = 2'd2;

    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_FULL      = 3'd1;
    localparam logic [2:0] STAT_NOT_FOUND = 3'd2;
    localparam logic [2:0] STAT_BAD_ADDR  = 3'd3;
    localparam logic [2:0] STAT_NULL      = 3'd4;

    localparam logic [1:0] FLAGS_PRESENT_RW = 2'd3;
    localparam logic [1:0] FLAGS_NONE       = 2'd0;

    typedef struct packed {
        logic             en;
        logic             occ;
        logic [IDX_W-1:0] addr;
        logic [31:0]      data;
    } store_wr_t;

    typedef struct packed {
        logic        occ;
        logic [31:0] data;
    } store_rd_t;

endpackage

>>> rtl/page_window_slot_allocator_core.sv
// ----------------------------------------------------------------------------
// Page window slot allocator core
// Maps and unmaps pages in a window of slots with a lowest-free hint.
// ----------------------------------------------------------------------------
// Channel  | Dir | Handshake          | Contents
// s_       | in  | s_tvalid/s_tready  | request word: action, page_ref, virt_addr
// m_       | out | m_tvalid/m_tready  | result word: status and mapping command
// cfg_     | in  | cfg_valid/cfg_ready| window_base register, always ready
//
// A request that finds its slot passes through scan, commit and done; a failed
// scan and a request refused before any scan go straight to done.
// A map scans up from the hint and an unmap by page from slot 0, examining the
// slots in turn through the single read port of the slot memory.
// Reset empties every slot at once through the occupancy flops.
// A result waits in the output register while m_tready is low.
// ----------------------------------------------------------------------------
module page_window_slot_allocator_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // page_ref [31:0], virt_addr [63:32]
    input  logic [1:0]  s_tuser,   // action [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // slot_index [7:0], mapped_addr [39:8], map_target [71:40],
    // map_flags [73:72], zero [79:74]
    output logic [79:0] m_tdata,
    output logic [2:0]  m_tuser,   // status [2:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;
    localparam logic [1:0] S_DONE   = 2'd3;

    localparam logic [pwsa_pkg::IDX_W-1:0] LAST_SLOT =
        pwsa_pkg::IDX_W'(pwsa_pkg::SLOTS - 1);

    logic [1:0]                  state_reg, state_next;
    logic [1:0]                  mode_reg, mode_next;
    logic [31:0]                 page_reg, page_next;
    logic [pwsa_pkg::IDX_W-1:0]  ptr_reg, ptr_next;
    logic [pwsa_pkg::IDX_W-1:0]  last_reg, last_next;
    logic                        issue_done_reg, issue_done_next;
    logic                        pend_reg, pend_next;
    logic [pwsa_pkg::IDX_W-1:0]  chk_idx_reg, chk_idx_next;
    logic [pwsa_pkg::IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    logic [pwsa_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [pwsa_pkg::IDX_W-1:0]  hint_reg, hint_next;
    logic [31:0]                 base_reg;
    logic [2:0]                  res_status_reg, res_status_next;
    logic [7:0]                  res_idx_reg, res_idx_next;
    logic [31:0]                 res_addr_reg, res_addr_next;
    logic [31:0]                 res_target_reg, res_target_next;
    logic [1:0]                  res_flags_reg, res_flags_next;
    logic                        m_valid_reg, m_valid_next;
    logic [79:0]                 m_data_reg;
    logic [2:0]                  m_user_reg;
    logic                        out_load;

    logic [31:0]                 in_page;
    logic [31:0]                 in_vaddr;
    logic [31:0]                 win_offset;
    logic [pwsa_pkg::VPN_W-1:0]  win_page;
    logic                        hit;
    pwsa_pkg::store_wr_t         st_wr;
    pwsa_pkg::store_rd_t         st_rd;

    assign in_page    = s_tdata[31:0];
    assign in_vaddr   = s_tdata[63:32];
    assign win_offset = in_vaddr - base_reg;
    assign win_page   = win_offset[31:pwsa_pkg::PAGE_SHIFT];

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    pwsa_slot_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (st_wr),
        .rd_addr (ptr_reg),
        .rd      (st_rd)
    );

    // Shared compare: a map looks for an empty slot, an unmap by page for a
    // matching occupied slot, an unmap by address for an occupied slot.
    always_comb begin
        case (mode_reg)
            pwsa_pkg::ACT_MAP:        hit = !st_rd.occ;
            pwsa_pkg::ACT_UNMAP_PAGE: hit = st_rd.occ && (st_rd.data == page_reg);
            default:                  hit = st_rd.occ;
        endcase
    end

    assign out_load = (state_reg == S_DONE) && (!m_valid_reg || m_tready);

    always_comb begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        page_next       = page_reg;
        ptr_next        = ptr_reg;
        last_next       = last_reg;
        issue_done_next = issue_done_reg;
        pend_next       = 1'b0;
        chk_idx_next    = chk_idx_reg;
        hit_idx_next    = hit_idx_reg;
        count_next      = count_reg;
        hint_next       = hint_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        res_addr_next   = res_addr_reg;
        res_target_next = res_target_reg;
        res_flags_next  = res_flags_reg;
        st_wr           = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    mode_next       = s_tuser;
                    page_next       = in_page;
                    issue_done_next = 1'b0;
                    res_status_next = pwsa_pkg::STAT_OK;
                    res_idx_next    = '0;
                    res_addr_next   = '0;
                    res_target_next = '0;
                    res_flags_next  = pwsa_pkg::FLAGS_NONE;
                    state_next      = S_DONE;
                    case (s_tuser)
                        pwsa_pkg::ACT_MAP: begin
                            if (in_page == '0) begin
                                res_status_next = pwsa_pkg::STAT_NULL;
                            end else if (count_reg == '0) begin
                                res_status_next = pwsa_pkg::STAT_FULL;
                            end else begin
                                ptr_next   = hint_reg;
                                last_next  = LAST_SLOT;
                                state_next = S_SCAN;
                            end
                        end
                        pwsa_pkg::ACT_UNMAP_PAGE: begin
                            if (in_page == '0) begin
                                res_status_next = pwsa_pkg::STAT_NULL;
                            end else begin
                                ptr_next   = '0;
                                last_next  = LAST_SLOT;
                                state_next = S_SCAN;
                            end
                        end
                        pwsa_pkg::ACT_UNMAP_ADDR: begin
                            if (win_page < pwsa_pkg::VPN_W'(pwsa_pkg::SLOTS)) begin
                                ptr_next   = win_page[pwsa_pkg::IDX_W-1:0];
                                last_next  = win_page[pwsa_pkg::IDX_W-1:0];
                                state_next = S_SCAN;
                            end else begin
                                res_status_next = pwsa_pkg::STAT_BAD_ADDR;
                            end
                        end
                        default: begin
                            res_status_next = pwsa_pkg::STAT_BAD_ADDR;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // One slot read is issued per cycle and checked in the cycle after.
                if (!issue_done_reg) begin
                    pend_next    = 1'b1;
                    chk_idx_next = ptr_reg;
                    if (ptr_reg == last_reg) begin
                        issue_done_next = 1'b1;
                    end else begin
                        ptr_next = ptr_reg + 1'b1;
                    end
                end
                if (pend_reg) begin
                    if (hit) begin
                        hit_idx_next = chk_idx_reg;
                        pend_next    = 1'b0;
                        state_next   = S_COMMIT;
                    end else if (chk_idx_reg == last_reg) begin
                        pend_next  = 1'b0;
                        state_next = S_DONE;
                        case (mode_reg)
                            pwsa_pkg::ACT_MAP:
                                res_status_next = pwsa_pkg::STAT_FULL;
                            pwsa_pkg::ACT_UNMAP_PAGE:
                                res_status_next = pwsa_pkg::STAT_NOT_FOUND;
                            default:
                                res_status_next = pwsa_pkg::STAT_BAD_ADDR;
                        endcase
                    end
                end
            end
            S_COMMIT: begin
                st_wr.en        = 1'b1;
                st_wr.addr      = hit_idx_reg;
                st_wr.data      = page_reg;
                st_wr.occ       = (mode_reg == pwsa_pkg::ACT_MAP);
                res_status_next = pwsa_pkg::STAT_OK;
                res_idx_next    = 8'(hit_idx_reg);
                res_addr_next   = base_reg + (32'(hit_idx_reg) << pwsa_pkg::PAGE_SHIFT);
                if (mode_reg == pwsa_pkg::ACT_MAP) begin
                    count_next      = count_reg - 1'b1;
                    hint_next       = hit_idx_reg;
                    res_target_next = page_reg;
                    res_flags_next  = pwsa_pkg::FLAGS_PRESENT_RW;
                end else begin
                    count_next      = count_reg + 1'b1;
                    if (hit_idx_reg < hint_reg) begin
                        hint_next = hit_idx_reg;
                    end
                    res_target_next = '0;
                    res_flags_next  = pwsa_pkg::FLAGS_NONE;
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            issue_done_reg <= 1'b0;
            pend_reg       <= 1'b0;
            count_reg      <= pwsa_pkg::CNT_W'(pwsa_pkg::SLOTS);
            hint_reg       <= '0;
            base_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            issue_done_reg <= issue_done_next;
            pend_reg       <= pend_next;
            count_reg      <= count_next;
            hint_reg       <= hint_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_valid) begin
                base_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg       <= mode_next;
        page_reg       <= page_next;
        ptr_reg        <= ptr_next;
        last_reg       <= last_next;
        chk_idx_reg    <= chk_idx_next;
        hit_idx_reg    <= hit_idx_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        res_addr_reg   <= res_addr_next;
        res_target_reg <= res_target_next;
        res_flags_reg  <= res_flags_next;
        if (out_load) begin
            m_user_reg <= res_status_reg;
            m_data_reg <= {6'd0, res_flags_reg, res_target_reg, res_addr_reg, res_idx_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // The free count never exceeds the number of slots.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= pwsa_pkg::CNT_W'(pwsa_pkg::SLOTS))
        else $error("free count above slot count");

    // An accepted request always leaves the idle state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg != S_IDLE))
        else $error("accepted request not started");

    // A failed request carries an all-zero mapping command.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != pwsa_pkg::STAT_OK)) |-> (m_tdata == '0))
        else $error("error result with nonzero payload");

    // A commit always follows a scan.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_COMMIT) |-> ($past(state_reg) == S_SCAN))
        else $error("commit without scan");

endmodule

>>> rtl/pwsa_slot_store.sv
// ----------------------------------------------------------------------------
// Slot store
// Page reference memory with one occupancy flop per slot; registered read.
// ----------------------------------------------------------------------------
module pwsa_slot_store (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  pwsa_pkg::store_wr_t       wr,
    input  logic [pwsa_pkg::IDX_W-1:0] rd_addr,
    output pwsa_pkg::store_rd_t       rd
);

    logic [31:0]               mem [pwsa_pkg::SLOTS];
    logic [pwsa_pkg::SLOTS-1:0] occ_reg;
    logic [31:0]               rd_data_reg;
    logic                      rd_occ_reg;

    // Page references are only meaningful where the occupancy bit is set.
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg    <= '0;
            rd_occ_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                occ_reg[wr.addr] <= wr.occ;
            end
            rd_occ_reg <= occ_reg[rd_addr];
        end
    end

    assign rd.occ  = rd_occ_reg;
    assign rd.data = rd_data_reg;

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// Page window slot allocator testbench
// Drives map, unmap-by-page and unmap-by-address requests into the slot
// allocator core under three window bases and three idling mixes. A shadow
// slot table predicts each result word that a directed row does not give,
// and each is compared field by field with what the core returns, in order.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = pwsa_pkg::SLOTS + 8;

    // Action code that the core does not define; it must be rejected.
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic       TYPED      = 1'b1;
    localparam logic       PREDICTED  = 1'b0;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  slot;
        logic [31:0] vaddr;
        logic [31:0] target;
        logic [1:0]  flags;
    } alloc_result_t;

    typedef struct packed {
        logic [1:0]    action;
        logic [31:0]   page;
        logic [31:0]   vaddr;
        logic          typed;
        alloc_result_t result;
    } req_row_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;   // page_ref [31:0], virt_addr [63:32]
    logic [1:0]  s_tuser   = '0;   // action [1:0]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    // slot_index [7:0], mapped_addr [39:8], map_target [71:40],
    // map_flags [73:72], zero [79:74]
    logic [79:0] m_tdata;
    logic [2:0]  m_tuser;          // status [2:0]
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data  = '0;

    page_window_slot_allocator_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    // Shadow of the core's state.
    logic [31:0] shadow_slot [pwsa_pkg::SLOTS];
    int          shadow_free = pwsa_pkg::SLOTS;
    int          shadow_hint = 0;
    logic [31:0] shadow_base = '0;

    alloc_result_t pending_results [$];
    alloc_result_t oldest_result;
    req_row_t      directed_rows [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int errors        = 0;
    int cycle_count   = 0;
    int requests_sent = 0;
    int seen_placed   = 0;
    int seen_released = 0;
    int seen_status [8];

    initial begin
        foreach (shadow_slot[i]) shadow_slot[i] = '0;
        foreach (seen_status[i]) seen_status[i] = 0;
    end

    function automatic logic [31:0] slot_vaddr(int idx);
        return shadow_base + (32'(idx) << pwsa_pkg::PAGE_SHIFT);
    endfunction

    function automatic alloc_result_t release_shadow(int idx);
        alloc_result_t r;
        r = '0;
        shadow_slot[idx] = '0;
        shadow_free++;
        if (idx < shadow_hint) shadow_hint = idx;
        r.status = pwsa_pkg::STAT_OK;
        r.slot   = idx[7:0];
        r.vaddr  = slot_vaddr(idx);
        r.target = '0;
        r.flags  = pwsa_pkg::FLAGS_NONE;
        return r;
    endfunction

    // Applies one request to the shadow table and returns the result word it
    // should produce.
    function automatic alloc_result_t resolve_request(logic [1:0] act, logic [31:0] page,
                                                      logic [31:0] va);
        alloc_result_t r;
        logic [31:0]   slotnum;
        int            i;
        r = '0;
        case (act)
            pwsa_pkg::ACT_MAP: begin
                if (page == '0) begin
                    r.status = pwsa_pkg::STAT_NULL;
                end else begin
                    r.status = pwsa_pkg::STAT_FULL;
                    if (shadow_free != 0) begin
                        for (i = shadow_hint;
                             i < pwsa_pkg::SLOTS && r.status != pwsa_pkg::STAT_OK;
                             i++) begin
                            if (shadow_slot[i] == '0) begin
                                shadow_slot[i] = page;
                                shadow_free--;
                                shadow_hint = i;
                                r.status = pwsa_pkg::STAT_OK;
                                r.slot   = i[7:0];
                                r.vaddr  = slot_vaddr(i);
                                r.target = page;
                                r.flags  = pwsa_pkg::FLAGS_PRESENT_RW;
                            end
                        end
                    end
                end
            end
            pwsa_pkg::ACT_UNMAP_PAGE: begin
                if (page == '0) begin
                    r.status = pwsa_pkg::STAT_NULL;
                end else begin
                    r.status = pwsa_pkg::STAT_NOT_FOUND;
                    for (i = 0;
                         i < pwsa_pkg::SLOTS && r.status != pwsa_pkg::STAT_OK;
                         i++) begin
                        if (shadow_slot[i] == page) r = release_shadow(i);
                    end
                end
            end
            pwsa_pkg::ACT_UNMAP_ADDR: begin
                slotnum = (va - shadow_base) >> pwsa_pkg::PAGE_SHIFT;
                if (slotnum >= pwsa_pkg::SLOTS) begin
                    r.status = pwsa_pkg::STAT_BAD_ADDR;
                end else if (shadow_slot[int'(slotnum)] == '0) begin
                    r.status = pwsa_pkg::STAT_BAD_ADDR;
                end else begin
                    r = release_shadow(int'(slotnum));
                end
            end
            default: r.status = pwsa_pkg::STAT_BAD_ADDR;
        endcase
        return r;
    endfunction

    function automatic req_row_t row(logic [1:0] act, logic [31:0] page, logic [31:0] va,
                                     logic typed, logic [2:0] st, logic [7:0] idx,
                                     logic [31:0] addr, logic [31:0] tgt, logic [1:0] fl);
        req_row_t r;
        r.action = act;
        r.page   = page;
        r.vaddr  = va;
        r.typed  = typed;
        r.result = '{status: st, slot: idx, vaddr: addr, target: tgt, flags: fl};
        return r;
    endfunction

    // Random index of an occupied slot, or -1 when the table is empty.
    function automatic int any_occupied();
        int start;
        int k;
        int j;
        if (shadow_free >= pwsa_pkg::SLOTS) return -1;
        start = $urandom_range(pwsa_pkg::SLOTS - 1);
        for (k = 0; k < pwsa_pkg::SLOTS; k++) begin
            j = (start + k) % pwsa_pkg::SLOTS;
            if (shadow_slot[j] != '0) return j;
        end
        return -1;
    endfunction

    // Mostly arbitrary pages, some from a small pool so duplicates occur, a few null.
    function automatic logic [31:0] pick_page();
        int v;
        v = $urandom_range(99);
        if (v < 3) return '0;
        if (v < 25) return 32'($urandom_range(1, 8));
        return $urandom;
    endfunction

    task automatic send_request(logic [1:0] act, logic [31:0] page, logic [31:0] va,
                                logic typed, alloc_result_t typed_result);
        alloc_result_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {va, page};
        s_tuser  <= act;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = resolve_request(act, page, va);
        pending_results.push_back(typed ? typed_result : predicted);
        requests_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_window(logic [31:0] base);
        cfg_valid <= 1'b1;
        cfg_data  <= base;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid   <= 1'b0;
        shadow_base = base;
    endtask

    // Random requests; map_pct steers the table toward full or toward empty.
    task automatic run_phase(int count, int map_pct);
        logic [1:0]  act;
        logic [31:0] page;
        logic [31:0] va;
        int          r;
        int          idx;
        repeat (count) begin
            r    = $urandom_range(99);
            page = pick_page();
            va   = $urandom;
            idx  = any_occupied();
            if (r < map_pct) begin
                act = pwsa_pkg::ACT_MAP;
            end else if (r < map_pct + (100 - map_pct) * 45 / 100) begin
                act = pwsa_pkg::ACT_UNMAP_PAGE;
                if (idx >= 0 && $urandom_range(99) < 75) page = shadow_slot[idx];
            end else if (r < map_pct + (100 - map_pct) * 90 / 100) begin
                act = pwsa_pkg::ACT_UNMAP_ADDR;
                r   = $urandom_range(99);
                if (idx >= 0 && r < 70) begin
                    va = slot_vaddr(idx) + 32'($urandom_range(4095));
                end else if (r < 90) begin
                    va = slot_vaddr($urandom_range(pwsa_pkg::SLOTS - 1))
                         + 32'($urandom_range(4095));
                end
            end else begin
                act = ACT_UNUSED;
            end
            send_request(act, page, va, PREDICTED, '0);
        end
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word, expected none, got status %0d data %h",
                         $time, m_tuser, m_tdata);
            end else begin
                oldest_result = pending_results.pop_front();
                check_field("status", 32'(oldest_result.status), 32'(m_tuser));
                check_field("slot_index", 32'(oldest_result.slot), 32'(m_tdata[7:0]));
                check_field("mapped_addr", oldest_result.vaddr, m_tdata[39:8]);
                check_field("map_target", oldest_result.target, m_tdata[71:40]);
                check_field("map_flags", 32'(oldest_result.flags), 32'(m_tdata[73:72]));
                seen_status[m_tuser]++;
                if (m_tuser == pwsa_pkg::STAT_OK && m_tdata[73:72] == pwsa_pkg::FLAGS_PRESENT_RW)
                    seen_placed++;
                if (m_tuser == pwsa_pkg::STAT_OK && m_tdata[73:72] == pwsa_pkg::FLAGS_NONE)
                    seen_released++;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: no progress within %0d cycles", $time, CYCLE_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        // Window base is 0 out of reset, so every mapped address below is slot << 12.
        directed_rows.push_back(row(pwsa_pkg::ACT_UNMAP_ADDR, 32'h0, 32'h0, TYPED,
                                    pwsa_pkg::STAT_BAD_ADDR, 8'd0, 32'h0, 32'h0,
                                    pwsa_pkg::FLAGS_NONE));
        directed_rows.push_back(row(pwsa_pkg::ACT_MAP, 32'h0, 32'hFFFF_FFFF, TYPED,
                                    pwsa_pkg::STAT_NULL, 8'd0, 32'h0, 32'h0,
                                    pwsa_pkg::FLAGS_NONE));
        directed_rows.push_back(row(pwsa_pkg::ACT_UNMAP_PAGE, 32'h0, 32'h0, TYPED,
                                    pwsa_pkg::STAT_NULL, 8'd0, 32'h0, 32'h0,
                                    pwsa_pkg::FLAGS_NONE));
        directed_rows.push_back(row(pwsa_pkg::ACT_UNMAP_PAGE, 32'hDEAD_BEEF, 32'h0, TYPED,
                                    pwsa_pkg::STAT_NOT_FOUND, 8'd0, 32'h0, 32'h0,
                                    pwsa_pkg::FLAGS_NONE));
        directed_rows.push_back(row(pwsa_pkg::ACT_MAP, 32'hFFFF_FFFF, 32'h0, TYPED,
                                    pwsa_pkg::STAT_OK, 8'd0, 32'h0, 32'hFFFF_FFFF,
                                    pwsa_pkg::FLAGS_PRESENT_RW));
        directed_rows.push_back(row(pwsa_pkg::ACT_MAP, 32'h0000_0001, 32'h0, TYPED,
                                    pwsa_pkg::STAT_OK, 8'd1, 32'h1000, 32'h1,
                                    pwsa_pkg::FLAGS_PRESENT_RW));
        // The same page goes into a second slot.
        directed_rows.push_back(row(pwsa_pkg::ACT_MAP, 32'hFFFF_FFFF, 32'h0, TYPED,
                                    pwsa_pkg::STAT_OK, 8'd2, 32'h2000, 32'hFFFF_FFFF,
                                    pwsa_pkg::FLAGS_PRESENT_RW));
        directed_rows.push_back(row(pwsa_pkg::ACT_MAP, 32'h1234_5678, 32'h0, TYPED,
                                    pwsa_pkg::STAT_OK, 8'd3, 32'h3000, 32'h1234_5678,
                                    pwsa_pkg::FLAGS_PRESENT_RW));
        // Unmap by page frees the lowest copy and pulls the hint back to it.
        directed_rows.push_back(row(pwsa_pkg::ACT_UNMAP_PAGE, 32'hFFFF_FFFF, 32'h0, TYPED,
                                    pwsa_pkg::STAT_OK, 8'd0, 32'h0, 32'h0,
                                    pwsa_pkg::FLAGS_NONE));
        directed_rows.push_back(row(pwsa_pkg::ACT_MAP, 32'hA5A5_A5A5, 32'h0, TYPED,
                                    pwsa_pkg::STAT_OK, 8'd0, 32'h0, 32'hA5A5_A5A5,
                                    pwsa_pkg::FLAGS_PRESENT_RW));
        directed_rows.push_back(row(pwsa_pkg::ACT_UNMAP_PAGE, 32'hFFFF_FFFF, 32'h0, TYPED,
                                    pwsa_pkg::STAT_OK, 8'd2, 32'h2000, 32'h0,
                                    pwsa_pkg::FLAGS_NONE));
        // Offset bits below the page size are ignored.
        directed_rows.push_back(row(pwsa_pkg::ACT_UNMAP_ADDR, 32'h0, 32'h0000_1FFF, TYPED,
                                    pwsa_pkg::STAT_OK, 8'd1, 32'h1000, 32'h0,
                                    pwsa_pkg::FLAGS_NONE));
        directed_rows.push_back(row(pwsa_pkg::ACT_UNMAP_ADDR, 32'h0, 32'h0000_1000, TYPED,
                                    pwsa_pkg::STAT_BAD_ADDR, 8'd0, 32'h0, 32'h0,
                                    pwsa_pkg::FLAGS_NONE));
        directed_rows.push_back(row(pwsa_pkg::ACT_UNMAP_ADDR, 32'h0, 32'h0010_0000, TYPED,
                                    pwsa_pkg::STAT_BAD_ADDR, 8'd0, 32'h0, 32'h0,
                                    pwsa_pkg::FLAGS_NONE));
        directed_rows.push_back(row(pwsa_pkg::ACT_UNMAP_ADDR, 32'h0, 32'hFFFF_FFFF, TYPED,
                                    pwsa_pkg::STAT_BAD_ADDR, 8'd0, 32'h0, 32'h0,
                                    pwsa_pkg::FLAGS_NONE));
        directed_rows.push_back(row(ACT_UNUSED, 32'h5555_AAAA, 32'hAAAA_5555, TYPED,
                                    pwsa_pkg::STAT_BAD_ADDR, 8'd0, 32'h0, 32'h0,
                                    pwsa_pkg::FLAGS_NONE));
        directed_rows.push_back(row(pwsa_pkg::ACT_UNMAP_ADDR, 32'h0, 32'h000F_F000, TYPED,
                                    pwsa_pkg::STAT_BAD_ADDR, 8'd0, 32'h0, 32'h0,
                                    pwsa_pkg::FLAGS_NONE));
        directed_rows.push_back(row(pwsa_pkg::ACT_MAP, 32'h5A5A_5A5A, 32'h0, PREDICTED,
                                    '0, '0, '0, '0, '0));
        directed_rows.push_back(row(pwsa_pkg::ACT_MAP, 32'h0000_0002, 32'h0, PREDICTED,
                                    '0, '0, '0, '0, '0));
        directed_rows.push_back(row(pwsa_pkg::ACT_MAP, 32'h8000_0000, 32'h0, PREDICTED,
                                    '0, '0, '0, '0, '0));
        directed_rows.push_back(row(pwsa_pkg::ACT_UNMAP_PAGE, 32'h1234_5678, 32'h0, PREDICTED,
                                    '0, '0, '0, '0, '0));
        directed_rows.push_back(row(pwsa_pkg::ACT_UNMAP_PAGE, 32'h0000_0001, 32'h0, PREDICTED,
                                    '0, '0, '0, '0, '0));

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 20;
        recv_idle_pct = 81;
        foreach (directed_rows[i])
            send_request(directed_rows[i].action, directed_rows[i].page,
                         directed_rows[i].vaddr, directed_rows[i].typed,
                         directed_rows[i].result);

        // Top of the address space, so slot addresses wrap past zero.
        drain();
        write_window(32'hFFFF_F000);
        run_phase(120, 45);

        // Map-heavy mix that drives the table to full.
        drain();
        send_idle_pct = 81;
        recv_idle_pct = 20;
        write_window(32'($urandom_range(0, 32'hFFFF_F000)));
        run_phase(280, 93);

        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_window(32'h0);
        run_phase(120, 25);

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Sent %0d requests under three window bases and three idling mixes.",
                 requests_sent);
        $display("Results: %0d placed, %0d released, %0d full, %0d not found, %0d bad, %0d null.",
                 seen_placed, seen_released, seen_status[pwsa_pkg::STAT_FULL],
                 seen_status[pwsa_pkg::STAT_NOT_FOUND], seen_status[pwsa_pkg::STAT_BAD_ADDR],
                 seen_status[pwsa_pkg::STAT_NULL]);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", errors);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
